// File: sv/infix_to_postfix_converter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix-to-postfix converter
// Short forms for the concurrent checks used in the control module.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Check that is switched off while reset is asserted.
`define I2P_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define I2P_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/i2p_pkg.sv
// ----------------------------------------------------------------------------
// Infix-to-postfix converter package
// Shared sizes, character codes, types and helper functions.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CHAR_W      = 8;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [CNT_W-1:0] STACK_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] LPAREN     = 8'h28;
  localparam logic [CHAR_W-1:0] RPAREN     = 8'h29;
  localparam logic [CHAR_W-1:0] STAR_CHAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] SLASH_CHAR = 8'h2F;
  localparam logic [CHAR_W-1:0] DIGIT_LO   = 8'h30;
  localparam logic [CHAR_W-1:0] DIGIT_HI   = 8'h39;
  localparam logic [CHAR_W-1:0] UPPER_LO   = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_HI   = 8'h5A;
  localparam logic [CHAR_W-1:0] CARET_CHAR = 8'h5E;
  localparam logic [CHAR_W-1:0] LOWER_LO   = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_HI   = 8'h7A;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_e;

  typedef enum logic [2:0] {
    CC_SPACE,
    CC_ALNUM,
    CC_LPAREN,
    CC_RPAREN,
    CC_OPER
  } char_class_e;

  // Shift command for the row of stack cells; cell 0 holds the top.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CHAR_W-1:0] push_data;
  } stack_cmd_t;

  function automatic logic [1:0] precedence(input logic [CHAR_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == PLUS_CHAR || c == MINUS_CHAR) p = 2'd1;
    if (c == STAR_CHAR || c == SLASH_CHAR) p = 2'd2;
    if (c == CARET_CHAR)                   p = 2'd3;
    return p;
  endfunction

  function automatic char_class_e classify(input logic [CHAR_W-1:0] c);
    char_class_e cc;
    cc = CC_OPER;
    if ((c >= DIGIT_LO && c <= DIGIT_HI) || (c >= UPPER_LO && c <= UPPER_HI) ||
        (c >= LOWER_LO && c <= LOWER_HI)) begin
      cc = CC_ALNUM;
    end
    if (c == SPACE_CHAR) cc = CC_SPACE;
    if (c == LPAREN)     cc = CC_LPAREN;
    if (c == RPAREN)     cc = CC_RPAREN;
    return cc;
  endfunction

endpackage

// File: sv/i2p_cell.sv
// ----------------------------------------------------------------------------
// Stack cell
// Holds one stack entry; takes the entry above on a push, below on a pop.
// ----------------------------------------------------------------------------
module i2p_cell (
  input  logic                      clk_i,
  input  i2p_pkg::stack_cmd_t       cmd_i,
  input  logic [i2p_pkg::CHAR_W-1:0] above_i,
  input  logic [i2p_pkg::CHAR_W-1:0] below_i,
  output logic [i2p_pkg::CHAR_W-1:0] data_o
);
  import i2p_pkg::*;

  logic [CHAR_W-1:0] data_q;
  logic [CHAR_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.push) begin
      data_d = above_i;
    end else if (cmd_i.pop) begin
      data_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: sv/i2p_ctrl.sv
// ----------------------------------------------------------------------------
// Converter control
// Sequences one input word at a time: emits, pops and pushes, and holds
// the stack fill count, the overflow flag and the output register.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_defines.svh"

module i2p_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [i2p_pkg::CHAR_W-1:0] ch_i,
  input  logic                       end_of_expr_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [i2p_pkg::CHAR_W-1:0] out_char_o,
  output logic                       last_o,
  output logic                       overflow_o,
  input  logic [i2p_pkg::CHAR_W-1:0] top_i,
  input  logic [i2p_pkg::CHAR_W-1:0] next_i,
  output i2p_pkg::stack_cmd_t        cmd_o
);
  import i2p_pkg::*;

  state_e            state_q, state_d;
  logic [CHAR_W-1:0] ch_q;
  logic              end_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              overflow_q, overflow_d;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q;
  logic              last_q;
  logic              out_ovf_q;

  logic              accept;
  logic              slot_free;
  logic              done;
  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic              top_pops;
  logic              next_pops;
  logic              stack_empty;
  logic [1:0]        prec_ch;
  logic [1:0]        prec_top;
  logic [1:0]        prec_next;
  char_class_e       cls;

  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign stack_empty = (cnt_q == '0);
  assign cls         = classify(ch_q);
  assign prec_ch     = precedence(ch_q);
  assign prec_top    = precedence(top_i);
  assign prec_next   = precedence(next_i);

  // A stacked operator is popped by the pending one when it binds tighter,
  // or equally tight and the pending one is not the right-associative caret.
  assign top_pops  = (top_i != LPAREN) &&
                     ((prec_top > prec_ch) || (prec_top == prec_ch && ch_q != CARET_CHAR));
  assign next_pops = (next_i != LPAREN) &&
                     ((prec_next > prec_ch) || (prec_next == prec_ch && ch_q != CARET_CHAR));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_WORK;
      end
      ST_WORK: begin
        if (done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    done        = 1'b0;
    emit        = 1'b0;
    emit_char   = top_i;
    emit_last   = 1'b0;
    cmd_o       = '{push: 1'b0, pop: 1'b0, push_data: ch_q};
    cnt_d       = cnt_q;
    overflow_d  = overflow_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_WORK: begin
        if (end_q) begin
          if (!stack_empty) begin
            if (slot_free) begin
              emit      = 1'b1;
              cmd_o.pop = 1'b1;
              cnt_d     = cnt_q - CNT_ONE;
            end
          end else if (slot_free) begin
            emit       = 1'b1;
            emit_char  = NUL_CHAR;
            emit_last  = 1'b1;
            cnt_d      = '0;
            overflow_d = 1'b0;
            done       = 1'b1;
          end
        end else begin
          case (cls)
            CC_SPACE: begin
              done = 1'b1;
            end
            CC_ALNUM: begin
              if (slot_free) begin
                emit      = 1'b1;
                emit_char = ch_q;
                emit_last = 1'b1;
                done      = 1'b1;
              end
            end
            CC_LPAREN: begin
              if (cnt_q == STACK_FULL) begin
                overflow_d = 1'b1;
              end else begin
                cmd_o.push = 1'b1;
                cnt_d      = cnt_q + CNT_ONE;
              end
              done = 1'b1;
            end
            CC_RPAREN: begin
              if (!stack_empty && top_i != LPAREN) begin
                if (slot_free) begin
                  emit      = 1'b1;
                  emit_last = (cnt_q == CNT_ONE) || (next_i == LPAREN);
                  cmd_o.pop = 1'b1;
                  cnt_d     = cnt_q - CNT_ONE;
                end
              end else begin
                // Discard the matching parenthesis, if there is one.
                if (!stack_empty) begin
                  cmd_o.pop = 1'b1;
                  cnt_d     = cnt_q - CNT_ONE;
                end
                done = 1'b1;
              end
            end
            CC_OPER: begin
              if (!stack_empty && top_pops) begin
                if (slot_free) begin
                  emit      = 1'b1;
                  emit_last = (cnt_q == CNT_ONE) || !next_pops;
                  cmd_o.pop = 1'b1;
                  cnt_d     = cnt_q - CNT_ONE;
                end
              end else begin
                if (cnt_q == STACK_FULL) begin
                  overflow_d = 1'b1;
                end else begin
                  cmd_o.push = 1'b1;
                  cnt_d      = cnt_q + CNT_ONE;
                end
                done = 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      overflow_q  <= overflow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= ch_i;
      end_q <= end_of_expr_i;
    end
    // The flag is sampled before an end word clears it.
    if (emit) begin
      out_char_q <= emit_char;
      last_q     <= emit_last;
      out_ovf_q  <= overflow_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;
  assign overflow_o  = out_ovf_q;

  `I2P_ASSERT(a_cnt_in_range, cnt_q <= STACK_FULL, "stack count beyond depth")
  `I2P_ASSERT(a_no_push_pop, !(cmd_o.push && cmd_o.pop), "push and pop together")
  `I2P_ASSERT(a_ovf_when_full, $rose(overflow_q) |-> $past(cnt_q) == STACK_FULL,
              "overflow set while stack not full")
  `I2P_ASSERT(a_emit_slot_free, emit |-> slot_free, "emit into occupied output register")
  `I2P_ASSERT_ALWAYS(a_idle_quiet, state_q == ST_IDLE |-> !emit && !cmd_o.push && !cmd_o.pop,
                     "stack or output activity while idle")

endmodule

// File: sv/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// Infix-to-postfix converter
// Shunting-yard conversion with the operator stack held in a row of cells.
// ----------------------------------------------------------------------------
// Usage: feed one character word per input handshake (ch_i, end_of_expr_i).
// Each word yields zero or more postfix words on the output channel; last_o
// marks the final word caused by one input word, and overflow_o carries the
// sticky flag for a push that was dropped on a full stack.
// An input word is taken while idle and then handled one step per cycle, not
// counting output stalls: one work step for its own action (emit, push, discard
// or terminator) plus one step per stacked entry popped. No new word is taken
// until its last step is done. The first output word is loaded into the output
// register in a work step, after the input word itself has been registered.
// An end word pops the whole stack, then sends a zero terminator with last_o
// set, and clears the fill count and the overflow flag.
// Reset empties the stack and the output register at once; no sweep is run.
// When the receiver stalls, the pending word holds in the output register
// and the block waits before emitting the next one.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [i2p_pkg::CHAR_W-1:0] ch_i,
  input  logic                       end_of_expr_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [i2p_pkg::CHAR_W-1:0] out_char_o,
  output logic                       last_o,
  output logic                       overflow_o
);
  import i2p_pkg::*;

  stack_cmd_t        cmd;
  logic [CHAR_W-1:0] cell_data [STACK_DEPTH];

  i2p_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ch_i          (ch_i),
    .end_of_expr_i (end_of_expr_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_char_o    (out_char_o),
    .last_o        (last_o),
    .overflow_o    (overflow_o),
    .top_i         (cell_data[0]),
    .next_i        (cell_data[1]),
    .cmd_o         (cmd)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [CHAR_W-1:0] above;
    logic [CHAR_W-1:0] below;

    if (i == 0) begin : g_top
      assign above = cmd.push_data;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = NUL_CHAR;
    end else begin : g_upper
      assign below = cell_data[i+1];
    end

    i2p_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .above_i (above),
      .below_i (below),
      .data_o  (cell_data[i])
    );
  end

endmodule
